FILE: hdl/assert_macros.svh
// assertion macros used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/rrtss_pkg.sv
// types, codes and reset values of the round-robin time-slice scheduler
package rrtss_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;

	// opcodes
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_SLICE   = 1'b1;

	// result status codes
	localparam logic [2:0] ST_ACCEPTED  = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_SLICE_RUN = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_HALTED    = 3'd4;

	// configuration port
	localparam int         PADDR_W        = 3;
	localparam int         REG_SEL_BIT    = 2;
	localparam logic       REG_QUANTUM    = 1'b0;
	localparam logic       REG_TIME_LIMIT = 1'b1;
	localparam logic [7:0]  QUANTUM_RST    = 8'd4;
	localparam logic [15:0] TIME_LIMIT_RST = 16'd49;

	localparam int QCOUNT_W = 5;

	typedef struct packed {
		logic       opcode;
		logic [7:0] job_id;
		logic [7:0] job_burst;
	} cmd_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [7:0]          served_id;
		logic [15:0]         end_time;
		logic                job_done;
		logic [15:0]         saved_time;
		logic [15:0]         slice_index;
		logic [QCOUNT_W-1:0] queue_count;
	} result_t;

	typedef struct packed {
		logic [7:0] job_id;
		logic [7:0] burst;
	} job_entry_t;

	typedef struct packed {
		logic [7:0]  quantum;
		logic [15:0] time_limit;
	} cfg_t;

endpackage

FILE: hdl/rrtss_cfg.sv
// apb-style configuration registers: quantum and time limit
module rrtss_cfg import rrtss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output cfg_t               cfg
);

	logic [7:0]  quantum_q;
	logic [15:0] time_limit_q;
	logic        wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q    <= QUANTUM_RST;
			time_limit_q <= TIME_LIMIT_RST;
		end else if (wr_en) begin
			unique case (paddr[REG_SEL_BIT])
				REG_QUANTUM:    quantum_q    <= pwdata[7:0];
				REG_TIME_LIMIT: time_limit_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_QUANTUM:    prdata = {24'd0, quantum_q};
			REG_TIME_LIMIT: prdata = {16'd0, time_limit_q};
		endcase
	end

	assign cfg.quantum    = quantum_q;
	assign cfg.time_limit = time_limit_q;

endmodule

FILE: hdl/rrtss_job_mem.sv
// job queue memory: one write port, one registered read port with write bypass
module rrtss_job_mem import rrtss_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]       waddr,
	input  job_entry_t                           wdata,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]       raddr,
	output job_entry_t                           rdata
);

	job_entry_t mem_q [QUEUE_DEPTH];
	job_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// a write to the slot being read lands in the read register directly
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/rrtss_core.sv
// scheduler state, single-pass step logic and result register
module rrtss_core import rrtss_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_vld,
	input  cmd_t                           item,
	input  cfg_t                           cfg,
	input  job_entry_t                     head_entry,
	output logic                           mem_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] mem_waddr,
	output job_entry_t                     mem_wdata,
	output logic [$clog2(QUEUE_DEPTH)-1:0] mem_raddr,
	output logic                           res_vld,
	output result_t                        res
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

	logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [15:0]      elapsed_q, elapsed_d, unused_q, unused_d, slices_q, slices_d;
	logic [2:0]       status_c;
	logic [7:0]       served_c;
	logic             done_c;
	logic [QCOUNT_W+CNT_W-1:0] cnt_ext;
	result_t          res_d;
	result_t          res_s2;
	logic             res_vld_s2;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		cnt_d     = cnt_q;
		elapsed_d = elapsed_q;
		unused_d  = unused_q;
		slices_d  = slices_q;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = head_entry;
		status_c  = ST_ACCEPTED;
		served_c  = 8'd0;
		done_c    = 1'b0;
		if (item_vld) begin
			unique case (item.opcode)
				OP_ENQUEUE: begin
					if (cnt_q == FULL_CNT) begin
						status_c = ST_FULL;
					end else begin
						mem_we           = 1'b1;
						mem_wdata.job_id = item.job_id;
						mem_wdata.burst  = item.job_burst;
						tail_d           = next_slot(tail_q);
						cnt_d            = cnt_q + CNT_W'(1);
					end
				end
				OP_SLICE: begin
					if (elapsed_q >= cfg.time_limit) begin
						status_c = ST_HALTED;
					end else if (cnt_q == '0) begin
						status_c = ST_EMPTY;
					end else begin
						status_c = ST_SLICE_RUN;
						served_c = head_entry.job_id;
						head_d   = next_slot(head_q);
						slices_d = sat_add16(slices_q, 16'd1);
						if (head_entry.burst > cfg.quantum) begin
							// rotate the job to the tail with its burst cut by one quantum
							mem_we          = 1'b1;
							mem_wdata.burst = head_entry.burst - cfg.quantum;
							tail_d          = next_slot(tail_q);
							elapsed_d       = sat_add16(elapsed_q, {8'd0, cfg.quantum});
						end else begin
							elapsed_d = sat_add16(elapsed_q, {8'd0, head_entry.burst});
							unused_d  = sat_add16(unused_q,
								{8'd0, cfg.quantum - head_entry.burst});
							cnt_d     = cnt_q - CNT_W'(1);
							done_c    = 1'b1;
						end
					end
				end
			endcase
		end
	end

	// read the slot that will be the head once this beat is applied
	assign mem_raddr = head_d;

	assign cnt_ext = {{QCOUNT_W{1'b0}}, cnt_d};

	always_comb begin
		res_d.status      = status_c;
		res_d.served_id   = served_c;
		res_d.end_time    = elapsed_d;
		res_d.job_done    = done_c;
		res_d.saved_time  = unused_d;
		res_d.slice_index = slices_d;
		res_d.queue_count = cnt_ext[QCOUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
			elapsed_q  <= '0;
			unused_q   <= '0;
			slices_q   <= '0;
			res_vld_s2 <= 1'b0;
		end else begin
			head_q     <= head_d;
			tail_q     <= tail_d;
			cnt_q      <= cnt_d;
			elapsed_q  <= elapsed_d;
			unused_q   <= unused_d;
			slices_q   <= slices_d;
			res_vld_s2 <= item_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (item_vld) begin
			res_s2 <= res_d;
		end
	end

	assign res_vld = res_vld_s2;
	assign res     = res_s2;

endmodule

FILE: hdl/round_robin_time_slice_scheduler_top.sv
// a command taken on start is registered into item_s1, then its result into res_s2; done high one cycle
// throughput: one command per cycle, busy never rises; the head job is prefetched from the
// job memory read port so a slice never waits on the read
// reset: pointers, job count, elapsed, saved and slice totals clear; quantum 4, limit 49
// the job memory is not cleared; results are strobes and are not held for the receiver
module round_robin_time_slice_scheduler_top import rrtss_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	output logic               done,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	`include "assert_macros.svh"

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cfg_t             cfg;
	cmd_t             item_s1;
	logic             valid_s1;
	job_entry_t       head_entry;
	logic             mem_we;
	logic [PTR_W-1:0] mem_waddr;
	logic [PTR_W-1:0] mem_raddr;
	job_entry_t       mem_wdata;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= cmd;
		end
	end

	rrtss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rrtss_job_mem #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_job_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (head_entry)
	);

	rrtss_core #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_vld   (valid_s1),
		.item       (item_s1),
		.cfg        (cfg),
		.head_entry (head_entry),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.res_vld    (done),
		.res        (result)
	);

	// every accepted beat yields exactly one result, through valid_s1 and then the result register
	`ASSERT_NEXT(a_accept_gives_result, clk, arst_n, start && !busy, valid_s1 ##1 done)
	`ASSERT_IMPLIES(a_result_had_beat, clk, arst_n, done, $past(start && !busy, 2))
	// a retired job is only reported on a slice that ran
	`ASSERT_IMPLIES(a_done_only_on_slice, clk, arst_n, done && result.job_done,
		result.status == ST_SLICE_RUN)

endmodule

FILE: tb/round_robin_time_slice_scheduler_top_tb.sv
// self-checking testbench for the round-robin time-slice scheduler
module round_robin_time_slice_scheduler_top_tb;
	import rrtss_pkg::*;

	localparam int STALL_LIMIT = 600;
	localparam int MAX_GAP     = 30;
	localparam int SAT_MAX     = 65535;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	cmd_t               cmd;
	logic               done;
	result_t            result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	round_robin_time_slice_scheduler_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// scheduler shadow state
	job_entry_t  job_ring[$];
	logic [7:0]  quantum_q;
	logic [15:0] limit_q;
	int unsigned elapsed_q;
	int unsigned unused_q;
	int unsigned slices_q;

	result_t     expected_results[$];
	int          fail_count;
	int          status_hits[0:7];
	int          idle_pct;
	int          stall_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned sat16(input int unsigned v);
		return (v > SAT_MAX) ? SAT_MAX : v;
	endfunction

	function automatic result_t predict_result(input cmd_t c);
		result_t    r;
		job_entry_t j;
		r = '0;
		if (c.opcode == OP_ENQUEUE) begin
			if (job_ring.size() >= DEF_QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				j.job_id = c.job_id;
				j.burst  = c.job_burst;
				job_ring.push_back(j);
				r.status = ST_ACCEPTED;
			end
		end else if (elapsed_q >= limit_q) begin
			// limit check wins over the empty check
			r.status = ST_HALTED;
		end else if (job_ring.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			j = job_ring.pop_front();
			r.served_id = j.job_id;
			if (j.burst > quantum_q) begin
				j.burst   = j.burst - quantum_q;
				elapsed_q = sat16(elapsed_q + quantum_q);
				job_ring.push_back(j);
			end else begin
				elapsed_q  = sat16(elapsed_q + j.burst);
				unused_q   = sat16(unused_q + quantum_q - j.burst);
				r.job_done = 1'b1;
			end
			slices_q = sat16(slices_q + 1);
			r.status = ST_SLICE_RUN;
		end
		r.end_time    = elapsed_q[15:0];
		r.saved_time  = unused_q[15:0];
		r.slice_index = slices_q[15:0];
		r.queue_count = QCOUNT_W'(job_ring.size());
		status_hits[r.status]++;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 40)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// one beat per call; start is left high so the next beat can follow at once
	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		expected_results.push_back(predict_result(c));
	endtask

	task automatic enqueue_job(input logic [7:0] id, input logic [7:0] burst);
		cmd_t c;
		c.opcode    = OP_ENQUEUE;
		c.job_id    = id;
		c.job_burst = burst;
		send_cmd(c);
	endtask

	task automatic run_slice();
		cmd_t c;
		c.opcode    = OP_SLICE;
		c.job_id    = 8'($urandom);
		c.job_burst = 8'($urandom);
		send_cmd(c);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// write then read back one register; only called while idle
	task automatic write_register(input logic idx, input logic [15:0] value);
		logic [31:0] d;
		d = $urandom;
		if (idx == REG_QUANTUM)
			d[7:0] = value[7:0];
		else
			d[15:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx) << REG_SEL_BIT;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_QUANTUM)
			quantum_q = value[7:0];
		else
			limit_q = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_QUANTUM)
			check_field("quantum readback", {8'h00, quantum_q}, {8'h00, prdata[7:0]});
		else
			check_field("time_limit readback", limit_q, prdata[15:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// reset values: quantum 4, limit 49
	task automatic test_directed();
		run_slice();
		enqueue_job(8'h00, 8'd0);
		enqueue_job(8'hFF, 8'd255);
		enqueue_job(8'hA5, 8'd4);
		enqueue_job(8'h5A, 8'd5);
		enqueue_job(8'h01, 8'd1);
		for (int k = 0; k < 11; k++)
			enqueue_job(8'($urandom), 8'($urandom));
		// queue is full now, this job is dropped
		enqueue_job(8'h7E, 8'd9);
		// zero burst, rotate, exact quantum, rotate, short burst
		repeat (5) run_slice();
		quiesce();
		write_register(REG_TIME_LIMIT, 16'd0);
		run_slice();
		enqueue_job(8'h3C, 8'd2);
		quiesce();
	endtask

	task automatic test_mixed_traffic(input int phases, input int items_per_phase);
		int unsigned cap;
		logic [7:0]  q;
		int          top;
		int          enq_pct;
		int          n;
		logic [7:0]  b;
		for (int p = 0; p < phases; p++) begin
			quiesce();
			case (p % 4)
				0: q = 8'd1;
				1: q = 8'd255;
				2: q = 8'($urandom_range(1, 255));
				default: q = 8'($urandom_range(2, 16));
			endcase
			write_register(REG_QUANTUM, {8'h00, q});
			cap = ($urandom_range(9) < 7) ? SAT_MAX : elapsed_q + $urandom_range(20, 600);
			if (cap > SAT_MAX)
				cap = SAT_MAX;
			write_register(REG_TIME_LIMIT, cap[15:0]);
			for (int k = 0; k < items_per_phase; k++) begin
				n = job_ring.size();
				enq_pct = (n < 3) ? 75 : (n > 13) ? 25 : 50;
				if ($urandom_range(99) < enq_pct) begin
					top = 2 * int'(q);
					if (top > 255)
						top = 255;
					case ($urandom_range(9))
						0, 1, 2: b = 8'($urandom);
						3, 4, 5, 6: b = 8'($urandom_range(0, top));
						7: b = q;
						8: b = (q == 8'd255) ? q : q + 8'd1;
						default: b = $urandom_range(1) ? 8'd255 : 8'd0;
					endcase
					enqueue_job(8'($urandom), b);
				end else begin
					run_slice();
				end
			end
		end
		quiesce();
	endtask

	// short bursts under the widest quantum drive the saved total into saturation
	task automatic test_saved_saturation();
		int extra;
		quiesce();
		write_register(REG_QUANTUM, 16'd255);
		write_register(REG_TIME_LIMIT, 16'hFFFF);
		extra = 0;
		for (int k = 0; k < 400 && extra < 10; k++) begin
			if (unused_q == SAT_MAX)
				extra++;
			enqueue_job(8'($urandom), 8'($urandom_range(0, 2)));
			run_slice();
		end
		quiesce();
	endtask

	// with an empty queue at the limit the slice must report halted
	task automatic test_halt_priority();
		quiesce();
		write_register(REG_QUANTUM, 16'd255);
		write_register(REG_TIME_LIMIT, 16'hFFFF);
		while (job_ring.size() != 0 && elapsed_q < SAT_MAX)
			run_slice();
		run_slice();
		quiesce();
		write_register(REG_TIME_LIMIT, elapsed_q[15:0]);
		run_slice();
		enqueue_job(8'($urandom), 8'($urandom));
		run_slice();
		run_slice();
		quiesce();
		write_register(REG_TIME_LIMIT, 16'hFFFF);
	endtask

	task automatic test_elapsed_saturation();
		quiesce();
		write_register(REG_QUANTUM, 16'd254);
		write_register(REG_TIME_LIMIT, 16'hFFFF);
		for (int k = 0; k < 900 && elapsed_q < SAT_MAX; k++) begin
			if (job_ring.size() < 3)
				enqueue_job(8'($urandom), 8'($urandom_range(128, 255)));
			else
				run_slice();
		end
		// elapsed sits at the ceiling, which equals the limit
		run_slice();
		enqueue_job(8'($urandom), 8'($urandom));
		run_slice();
		run_slice();
		quiesce();
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 40)
					$display("%0t: result with nothing expected, expected none, got %h",
						$time, result);
			end else begin
				want = expected_results.pop_front();
				check_field("status", 16'(want.status), 16'(result.status));
				check_field("served_id", 16'(want.served_id), 16'(result.served_id));
				check_field("end_time", want.end_time, result.end_time);
				check_field("job_done", 16'(want.job_done), 16'(result.job_done));
				check_field("saved_time", want.saved_time, result.saved_time);
				check_field("slice_index", want.slice_index, result.slice_index);
				check_field("queue_count", 16'(want.queue_count), 16'(result.queue_count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1 || (psel && penable && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, stall_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		fail_count   = 0;
		idle_pct     = 18;
		quantum_q    = QUANTUM_RST;
		limit_q      = TIME_LIMIT_RST;
		elapsed_q    = 0;
		unused_q     = 0;
		slices_q     = 0;
		for (int s = 0; s < 8; s++)
			status_hits[s] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_mixed_traffic(4, 90);
		idle_pct = 82;
		test_saved_saturation();
		idle_pct = 0;
		test_halt_priority();
		test_mixed_traffic(3, 80);
		test_elapsed_saturation();

		quiesce();
		repeat (5) @(posedge clk);
		if (expected_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d results never arrived", $time, expected_results.size());
		end
		$display("covered: %0d accepted, %0d dropped on full, %0d slices, %0d empty, %0d halted",
			status_hits[ST_ACCEPTED], status_hits[ST_FULL], status_hits[ST_SLICE_RUN],
			status_hits[ST_EMPTY], status_hits[ST_HALTED]);
		$display("final totals: elapsed %0d, saved %0d, slices %0d", elapsed_q, unused_q, slices_q);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/rrtss_pkg.sv
hdl/rrtss_cfg.sv
hdl/rrtss_job_mem.sv
hdl/rrtss_core.sv
hdl/round_robin_time_slice_scheduler_top.sv
tb/round_robin_time_slice_scheduler_top_tb.sv
